>>> sv/aabb_body_step_resolver_macros.svh
// Assertion macros shared by the checker of the box-body step resolver.
// Depends on nothing; included by the checker file.
`ifndef AABB_BODY_STEP_RESOLVER_MACROS_SVH
`define AABB_BODY_STEP_RESOLVER_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define ABSR_ASSERT_IMP(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
        else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define ABSR_ASSERT_NEXT(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
        else $error("assertion failed");
`endif

>>> sv/absr_pkg.sv
// Package of the box-body step resolver: widths, defaults and saturation helper.
// Depends on nothing.
package absr_pkg;
    localparam int MAX_STATIC_DEF = 1024;
    localparam int MAX_HITS_DEF = 10;
    localparam logic [30:0] GRAVITY_RESET = 31'd642908;
    localparam logic [0:0] REG_GRAVITY = 1'b0;
    localparam logic [0:0] REG_STATIC_COUNT = 1'b1;
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_STEP = 1'b1;

    typedef struct packed {
        logic [0:0] op;
        logic [9:0] box_index;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic [30:0] size_x;
        logic [30:0] size_y;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic signed [31:0] force_x;
        logic signed [31:0] force_y;
        logic [15:0] dt;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] new_pos_x;
        logic signed [31:0] new_pos_y;
        logic signed [31:0] new_vel_x;
        logic signed [31:0] new_vel_y;
        logic [3:0] hit_count;
    } out_item_t;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic [30:0] w;
        logic [30:0] h;
    } box_t;

    // Clamp a 34-bit signed value to signed 32 bits.
    function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
        logic signed [31:0] r;
        if (v > 34'sd2147483647)
            r = 32'sh7fffffff;
        else if (v < -34'sd2147483648)
            r = 32'sh80000000;
        else
            r = v[31:0];
        return r;
    endfunction
endpackage

>>> sv/absr_if.sv
// Valid/ready channel interface carrying one item payload.
// Depends on nothing; the payload type is a parameter.
interface absr_if #(parameter type T = logic) (input logic clk);
    logic valid;
    logic ready;
    T data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

>>> sv/absr_mul_dt.sv
// Scaling of a signed Q16.16 value by an unsigned Q0.16 step, floor rounding.
// Depends on nothing; one multiplier, registered.
module absr_mul_dt (
    input  logic              clk,
    input  logic signed [31:0] a,
    input  logic [15:0]       dt,
    output logic signed [31:0] p_reg
);
    logic signed [48:0] prod;
    assign prod = a * $signed({1'b0, dt});
    // Arithmetic shift floors toward minus infinity; |result| < 2^31.
    always_ff @(posedge clk)
    begin
        p_reg <= prod[47:16];
    end
endmodule

>>> sv/aabb_body_step_resolver.sv
// Box-body step resolver. A box write (op 0) is taken while idle and gives no item.
// A body step passes FY, V1, V2, P1, P2, RES0, SCAN, then RES1 and RES2 for each hit, and
// DONE, where it waits until its result is loaded; the scan ends early at the hit limit.
// The scan reads one stored box a cycle from a synchronous memory with a registered read.
// One step is in work at a time; the next item can be taken in the cycle after the result is loaded.
// Reset (rst_n low, asynchronous) resets control and config, not data or the box table.
module aabb_body_step_resolver #(
    parameter int MAX_STATIC = absr_pkg::MAX_STATIC_DEF,
    parameter int MAX_HITS = absr_pkg::MAX_HITS_DEF
) (
    input  logic clk,
    input  logic rst_n,
    input  logic cfg_we,
    input  logic [0:0] cfg_index,
    input  logic [30:0] cfg_data,
    absr_if.sink   in_ch,
    absr_if.source out_ch
);
    localparam int AW = (MAX_STATIC > 1) ? $clog2(MAX_STATIC) : 1;
    localparam int HW = $clog2(MAX_HITS + 1);
    localparam int CW = $clog2(MAX_STATIC + 1);

    localparam logic [3:0] S_IDLE = 4'd0, S_FY = 4'd1, S_V1 = 4'd2, S_V2 = 4'd3,
        S_P1 = 4'd4, S_P2 = 4'd5, S_SCAN = 4'd6, S_RES1 = 4'd7, S_RES2 = 4'd8,
        S_DONE = 4'd9, S_RES0 = 4'd10;

    logic [3:0] state_reg;
    logic [30:0] gravity_reg;
    logic [10:0] count_reg;

    // Registers shared by the step.
    logic signed [31:0] bx_reg, by_reg, vx_reg, vy_reg, fx_reg, fy_reg;
    logic [30:0] bw_reg, bh_reg;
    logic [15:0] dt_reg;
    logic [CW-1:0] scan_reg;
    logic [CW-1:0] limit_reg;
    logic rd_valid_reg;
    logic [HW-1:0] hits_reg, res_reg;

    absr_pkg::box_t mem [MAX_STATIC];
    absr_pkg::box_t rd_reg;
    absr_pkg::box_t found [MAX_HITS];
    absr_pkg::box_t cur_box;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gravity_reg <= absr_pkg::GRAVITY_RESET;
            count_reg <= 11'd0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                absr_pkg::REG_GRAVITY: gravity_reg <= cfg_data;
                absr_pkg::REG_STATIC_COUNT: count_reg <= cfg_data[10:0];
                default: ;
            endcase
        end
    end

    // Box writes are still taken while a finished result waits for the receiver.
    assign in_ch.ready = (state_reg == S_IDLE);
    logic accept;
    assign accept = in_ch.valid && in_ch.ready;

    // The finished step moves into the output register once that register is free.
    logic out_load;
    assign out_load = (state_reg == S_DONE) && (!out_ch.valid || out_ch.ready);

    // Box table: one write port for op 0, one read port for the scan.
    logic [AW-1:0] rd_addr;
    assign rd_addr = scan_reg[AW-1:0];
    always_ff @(posedge clk)
    begin
        if (accept && in_ch.data.op == absr_pkg::OP_WRITE
            && {22'd0, in_ch.data.box_index} < MAX_STATIC)
            mem[AW'(in_ch.data.box_index)] <= '{in_ch.data.pos_x, in_ch.data.pos_y,
                in_ch.data.size_x, in_ch.data.size_y};
        rd_reg <= mem[rd_addr];
    end

    // Shared dt multiplier.
    logic signed [31:0] mul_a, mul_p;
    absr_mul_dt u_mul (.clk(clk), .a(mul_a), .dt(dt_reg), .p_reg(mul_p));
    always_comb
    begin
        case (state_reg)
            S_V1: mul_a = fy_reg;
            S_V2: mul_a = fx_reg;
            S_P1: mul_a = vy_reg;
            S_P2: mul_a = vx_reg;
            default: mul_a = fy_reg;
        endcase
    end

    // Overlap of body and the box read this cycle; inclusive corner containment.
    logic signed [33:0] ax0, ax1, ay0, ay1, qx0, qx1, qy0, qy1;
    logic hit;
    function automatic logic pin(input logic signed [33:0] x0, x1, y0, y1, px, py);
        return px >= x0 && px <= x1 && py <= y1 && py >= y0;
    endfunction
    always_comb
    begin
        ax0 = 34'(bx_reg);
        ax1 = 34'(bx_reg) + $signed({3'd0, bw_reg});
        ay1 = 34'(by_reg);
        ay0 = 34'(by_reg) - $signed({3'd0, bh_reg});
        qx0 = 34'(rd_reg.x);
        qx1 = 34'(rd_reg.x) + $signed({3'd0, rd_reg.w});
        qy1 = 34'(rd_reg.y);
        qy0 = 34'(rd_reg.y) - $signed({3'd0, rd_reg.h});
        hit = pin(ax0, ax1, ay0, ay1, qx0, qy1) || pin(ax0, ax1, ay0, ay1, qx1, qy1)
            || pin(ax0, ax1, ay0, ay1, qx0, qy0) || pin(ax0, ax1, ay0, ay1, qx1, qy0)
            || pin(qx0, qx1, qy0, qy1, ax0, ay1) || pin(qx0, qx1, qy0, qy1, ax1, ay1)
            || pin(qx0, qx1, qy0, qy1, ax0, ay0) || pin(qx0, qx1, qy0, qy1, ax1, ay0);
    end

    // Penetrations of the current hit, registered before the compare.
    logic signed [34:0] d0_reg, d1_reg, d2_reg, d3_reg;

    assign cur_box = found[res_reg[$clog2(MAX_HITS > 1 ? MAX_HITS : 2)-1:0]];

    logic [1:0] best;
    always_comb
    begin
        best = 2'd0;
        if (d1_reg < d0_reg) best = 2'd1;
        if (d2_reg < ((best == 2'd1) ? d1_reg : d0_reg)) best = 2'd2;
        if (d3_reg < ((best == 2'd2) ? d2_reg : (best == 2'd1) ? d1_reg : d0_reg))
            best = 2'd3;
    end

    logic signed [33:0] fy_diff;
    assign fy_diff = 34'(in_ch.data.force_y) - $signed({3'd0, gravity_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            out_ch.valid <= 1'b0;
            rd_valid_reg <= 1'b0;
            scan_reg <= '0;
            hits_reg <= '0;
            res_reg <= '0;
        end
        else
        begin
            if (out_load)
                out_ch.valid <= 1'b1;
            else if (out_ch.valid && out_ch.ready)
                out_ch.valid <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (accept && in_ch.data.op == absr_pkg::OP_STEP)
                    begin
                        bx_reg <= in_ch.data.pos_x;
                        by_reg <= in_ch.data.pos_y;
                        bw_reg <= in_ch.data.size_x;
                        bh_reg <= in_ch.data.size_y;
                        vx_reg <= in_ch.data.vel_x;
                        vy_reg <= in_ch.data.vel_y;
                        fx_reg <= in_ch.data.force_x;
                        fy_reg <= absr_pkg::sat32(fy_diff);
                        dt_reg <= in_ch.data.dt;
                        limit_reg <= (int'(count_reg) > MAX_STATIC)
                            ? CW'(MAX_STATIC) : CW'(count_reg);
                        state_reg <= S_FY;
                    end
                end
                S_FY: state_reg <= S_V1;
                S_V1: state_reg <= S_V2;
                S_V2:
                begin
                    vy_reg <= absr_pkg::sat32(34'(vy_reg) + 34'(mul_p));
                    state_reg <= S_P1;
                end
                S_P1:
                begin
                    vx_reg <= absr_pkg::sat32(34'(vx_reg) + 34'(mul_p));
                    state_reg <= S_P2;
                end
                S_P2:
                begin
                    by_reg <= absr_pkg::sat32(34'(by_reg) + 34'(mul_p));
                    state_reg <= S_RES0;
                end
                S_RES0:
                begin
                    bx_reg <= absr_pkg::sat32(34'(bx_reg) + 34'(mul_p));
                    state_reg <= S_SCAN;
                    scan_reg <= '0;
                    hits_reg <= '0;
                    rd_valid_reg <= 1'b0;
                end
                S_SCAN:
                begin
                    // rd_reg holds entry scan_reg - 1 whenever rd_valid_reg is set.
                    if (rd_valid_reg && hit && hits_reg < HW'(MAX_HITS))
                    begin
                        found[hits_reg[$clog2(MAX_HITS > 1 ? MAX_HITS : 2)-1:0]] <= rd_reg;
                        hits_reg <= hits_reg + 1'b1;
                    end
                    if (scan_reg < limit_reg)
                    begin
                        scan_reg <= scan_reg + 1'b1;
                        rd_valid_reg <= 1'b1;
                    end
                    else
                    begin
                        rd_valid_reg <= 1'b0;
                    end
                    if ((!rd_valid_reg && scan_reg >= limit_reg)
                        || (rd_valid_reg && hit && hits_reg + 1'b1 >= HW'(MAX_HITS)))
                    begin
                        state_reg <= S_RES1;
                        res_reg <= '0;
                    end
                end
                S_RES1:
                begin
                    if (res_reg >= hits_reg)
                        state_reg <= S_DONE;
                    else
                    begin
                        d0_reg <= 35'(cur_box.y) - (35'(by_reg) - $signed({4'd0, bh_reg}));
                        d1_reg <= 35'(by_reg) - (35'(cur_box.y) - $signed({4'd0, cur_box.h}));
                        d2_reg <= (35'(cur_box.x) + $signed({4'd0, cur_box.w})) - 35'(bx_reg);
                        d3_reg <= (35'(bx_reg) + $signed({4'd0, bw_reg})) - 35'(cur_box.x);
                        state_reg <= S_RES2;
                    end
                end
                S_RES2:
                begin
                    case (best)
                        2'd0: begin by_reg <= absr_pkg::sat32(34'(35'(by_reg) + d0_reg));
                            vy_reg <= '0; end
                        2'd1: begin by_reg <= absr_pkg::sat32(34'(35'(by_reg) - d1_reg));
                            vy_reg <= '0; end
                        2'd2: begin bx_reg <= absr_pkg::sat32(34'(35'(bx_reg) + d2_reg));
                            vx_reg <= '0; end
                        default: begin bx_reg <= absr_pkg::sat32(34'(35'(bx_reg) - d3_reg));
                            vx_reg <= '0; end
                    endcase
                    res_reg <= res_reg + 1'b1;
                    state_reg <= S_RES1;
                end
                S_DONE:
                begin
                    // Hold the finished step until the output register is free.
                    if (out_load)
                    begin
                        out_ch.data <= '{bx_reg, by_reg, vx_reg, vy_reg, 4'(hits_reg)};
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule

>>> sv/absr_checker.sv
// Port-level checker for the box-body step resolver, bound to the top level.
// Depends on aabb_body_step_resolver_macros.svh.
`include "aabb_body_step_resolver_macros.svh"
module absr_checker (
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input logic [3:0] hit_count
);
    `ABSR_ASSERT_NEXT(ready_holds, clk, rst_n, in_ready && !in_valid, in_ready)
    `ABSR_ASSERT_NEXT(out_holds, clk, rst_n, out_valid && !out_ready, out_valid)
    `ABSR_ASSERT_NEXT(hit_stable, clk, rst_n, out_valid && !out_ready, $stable(hit_count))
    `ABSR_ASSERT_IMP(hits_bounded, clk, rst_n, out_valid, hit_count <= 4'd10)
endmodule

bind aabb_body_step_resolver absr_checker u_chk (
    .clk(clk), .rst_n(rst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .hit_count(out_ch.data.hit_count)
);
